/* src/mals_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average level smoother package
// Shared widths, register codes, divider constants and the cell control type.
// ----------------------------------------------------------------------------
package mals_pkg;

   // Window length and field widths.
   localparam int WINDOW_LENGTH = 10;
   localparam int SAMPLE_W      = 8;
   localparam int LEVEL_W       = 7;
   localparam int TIME_W        = 32;
   localparam int INTERVAL_W    = 20;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   // Running total: enough bits for WINDOW_LENGTH samples of either sign.
   localparam int TOTAL_W = SAMPLE_W + $clog2(WINDOW_LENGTH);
   localparam int MAG_W   = TOTAL_W;

   // Rounded division by a reciprocal: floor((2*m + N) / (2*N)) is computed
   // exactly as (x * DIV_RECIP) >> DIV_SHIFT for every x below 2**DIV_XW.
   localparam int DIV_D     = 2 * WINDOW_LENGTH;
   localparam int DIV_XW    = TOTAL_W + 2;
   localparam int DIV_L     = $clog2(DIV_D);
   localparam int DIV_SHIFT = DIV_XW + DIV_L;
   localparam int DIV_RW    = DIV_XW + 1;
   localparam int DIV_PW    = DIV_XW + DIV_RW;
   localparam int DIV_QW    = DIV_PW - DIV_SHIFT;
   localparam logic [DIV_RW-1:0] DIV_RECIP =
      DIV_RW'(((64'd1 << DIV_SHIFT) + 64'(DIV_D) - 64'd1) / 64'(DIV_D));

   // Register reset values.
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = INTERVAL_W'(10000);
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX_RESET = LEVEL_W'(5);

   // Register index codes, taken from the word address.
   localparam logic CSR_IDX_INTERVAL  = 1'b0;
   localparam logic CSR_IDX_LEVEL_MAX = 1'b1;

   // Per-beat command to every cell of the sample chain.
   typedef struct packed {
      logic fill;   // load the incoming sample into every cell
      logic shift;  // take the neighbour's sample, or the new one at cell 0
   } cell_ctrl_type;

endpackage
`default_nettype wire

/* src/mals_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sample window cell
// Holds one window sample; fills from the new sample or shifts from its neighbour.
// ----------------------------------------------------------------------------
module mals_cell (
   input  wire logic                           clock,
   input  wire mals_pkg::cell_ctrl_type        ctrl,
   input  wire logic [mals_pkg::SAMPLE_W-1:0]  fill_sample,
   input  wire logic [mals_pkg::SAMPLE_W-1:0]  shift_in,
   output logic      [mals_pkg::SAMPLE_W-1:0]  sample_out
);

   logic [mals_pkg::SAMPLE_W-1:0] sample_ff;
   logic [mals_pkg::SAMPLE_W-1:0] sample_in;

   always_comb begin
      priority if (ctrl.fill) begin
         sample_in = fill_sample;
      end else if (ctrl.shift) begin
         sample_in = shift_in;
      end else begin
         sample_in = sample_ff;
      end
   end

   // Payload only: the window is always filled before it is read.
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

   assign sample_out = sample_ff;

endmodule
`default_nettype wire

/* src/mals_round.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rounding divider and clamp
// Divides the window total by the window length, half away from zero, and clamps.
// ----------------------------------------------------------------------------
module mals_round (
   input  wire logic [mals_pkg::TOTAL_W-1:0] total,
   input  wire logic [mals_pkg::LEVEL_W-1:0] level_max,
   output logic      [mals_pkg::LEVEL_W-1:0] level
);

   logic                            neg;
   logic [mals_pkg::TOTAL_W:0]      tot_ext;
   logic [mals_pkg::TOTAL_W:0]      neg_ext;
   logic [mals_pkg::MAG_W-1:0]      mag;
   logic [mals_pkg::DIV_XW-1:0]     num;
   logic [mals_pkg::DIV_PW-1:0]     prod;
   logic [mals_pkg::DIV_QW-1:0]     quo;

   // Work on the magnitude; the extra bit keeps the most negative total exact.
   assign neg     = total[mals_pkg::TOTAL_W-1];
   assign tot_ext = {total[mals_pkg::TOTAL_W-1], total};
   assign neg_ext = -tot_ext;
   assign mag     = neg ? neg_ext[mals_pkg::MAG_W-1:0] : total;

   assign num  = mals_pkg::DIV_XW'({mag, 1'b0}) + mals_pkg::DIV_XW'(mals_pkg::WINDOW_LENGTH);
   assign prod = mals_pkg::DIV_PW'(num) * mals_pkg::DIV_PW'(mals_pkg::DIV_RECIP);
   assign quo  = prod[mals_pkg::DIV_PW-1:mals_pkg::DIV_SHIFT];

   // A negative total rounds to zero or below, so it always clamps to zero.
   always_comb begin
      priority if (neg) begin
         level = '0;
      end else if (quo > mals_pkg::DIV_QW'(level_max)) begin
         level = level_max;
      end else begin
         level = quo[mals_pkg::LEVEL_W-1:0];
      end
   end

endmodule
`default_nettype wire

/* src/moving_average_level_smoother.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Moving average level smoother
// Boxcar average over a window of level samples, refilled after a time gap.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  req_sample (s8), req_now_ms (u32)
//   rsp_      out        rsp_valid/rsp_ready  rsp_level (u7)
//   APB       in/out     psel/penable/pready  refill interval at 0x0, level max at 0x4
//
// One beat can be accepted in every cycle unless a stalled result and a beat
// in the middle stage hold both stages. The total is registered as the beat
// is taken; the middle stage turns it into a level, which the output register
// holds until it leaves. The running total is updated once per accepted beat.
// Reset is synchronous and active high; it clears the total, the refill mark
// and the window-ready flag, so the first beat after reset refills the window.
// A stalled result holds in the output register while one more beat waits in
// the middle stage; req_ready only drops when both are occupied.
//
// Structure: the window is a chain of cells that shifts by one on each beat.
// The cell at the far end holds the oldest sample, which leaves the total as
// the new sample enters it. A refill loads the new sample into every cell and
// sets the total to sample times the window length. The middle stage then
// divides the total by the window length with a reciprocal multiply, rounds
// half away from zero and clamps to the programmed maximum.
// ----------------------------------------------------------------------------
module moving_average_level_smoother (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [mals_pkg::SAMPLE_W-1:0] req_sample,
   input  wire logic [mals_pkg::TIME_W-1:0]      req_now_ms,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [mals_pkg::LEVEL_W-1:0]     rsp_level,

   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [mals_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mals_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mals_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [mals_pkg::INTERVAL_W-1:0] interval_ff,  interval_in;
   logic [mals_pkg::LEVEL_W-1:0]    level_max_ff, level_max_in;
   logic                            csr_write;
   logic                            csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[2];

   always_comb begin
      interval_in  = interval_ff;
      level_max_in = level_max_ff;
      if (csr_write) begin
         unique case (csr_index)
            mals_pkg::CSR_IDX_INTERVAL: begin
               interval_in = pwdata[mals_pkg::INTERVAL_W-1:0];
            end
            mals_pkg::CSR_IDX_LEVEL_MAX: begin
               level_max_in = pwdata[mals_pkg::LEVEL_W-1:0];
            end
            default: begin
               interval_in = interval_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         mals_pkg::CSR_IDX_INTERVAL: begin
            prdata = mals_pkg::CSR_DATA_W'(interval_ff);
         end
         mals_pkg::CSR_IDX_LEVEL_MAX: begin
            prdata = mals_pkg::CSR_DATA_W'(level_max_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff  <= mals_pkg::INTERVAL_RESET;
         level_max_ff <= mals_pkg::LEVEL_MAX_RESET;
      end else begin
         interval_ff  <= interval_in;
         level_max_ff <= level_max_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_adv;
   logic accept;

   // The output register can take a new level when empty or being drained;
   // the middle stage can take a beat when empty or moving on.
   assign out_adv   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_adv;
   assign accept    = req_valid && req_ready;

   assign s1_valid_in  = accept ? 1'b1 : (out_adv ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_adv ? s1_valid_ff : rsp_valid_ff;

   // ------------------------------------------------------------------
   // Window state: refill decision and running total
   // ------------------------------------------------------------------
   logic [mals_pkg::TIME_W-1:0]   mark_ff, mark_in;
   logic                          ready_ff, ready_in;
   logic [mals_pkg::TOTAL_W-1:0]  total_ff, total_in;
   logic [mals_pkg::TIME_W-1:0]   elapsed;
   logic                          expire;
   logic                          refill;
   logic [mals_pkg::SAMPLE_W-1:0] sample_u;
   logic [mals_pkg::TOTAL_W-1:0]  sample_ext;
   logic [mals_pkg::TOTAL_W-1:0]  oldest_ext;
   logic [mals_pkg::TOTAL_W-1:0]  sum_total;
   logic [mals_pkg::TOTAL_W-1:0]  fill_total;
   mals_pkg::cell_ctrl_type       cell_ctrl;
   logic [mals_pkg::SAMPLE_W-1:0] cell_sample [mals_pkg::WINDOW_LENGTH];

   // Elapsed time wraps with the millisecond counter.
   assign elapsed = req_now_ms - mark_ff;
   assign expire  = elapsed > mals_pkg::TIME_W'(interval_ff);
   assign refill  = expire || !ready_ff;

   assign sample_u   = $unsigned(req_sample);
   assign sample_ext = {{(mals_pkg::TOTAL_W - mals_pkg::SAMPLE_W){sample_u[mals_pkg::SAMPLE_W-1]}},
                        sample_u};
   assign oldest_ext =
      {{(mals_pkg::TOTAL_W - mals_pkg::SAMPLE_W)
        {cell_sample[mals_pkg::WINDOW_LENGTH-1][mals_pkg::SAMPLE_W-1]}},
       cell_sample[mals_pkg::WINDOW_LENGTH-1]};
   assign sum_total  = total_ff + sample_ext - oldest_ext;
   assign fill_total = sample_ext * mals_pkg::TOTAL_W'(mals_pkg::WINDOW_LENGTH);

   assign cell_ctrl.fill  = accept && refill;
   assign cell_ctrl.shift = accept && !refill;

   always_comb begin
      mark_in  = mark_ff;
      ready_in = ready_ff;
      total_in = total_ff;
      if (accept) begin
         if (expire) begin
            mark_in = req_now_ms;
         end
         if (refill) begin
            total_in = fill_total;
            ready_in = 1'b1;
         end else begin
            total_in = sum_total;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff      <= '0;
         ready_ff     <= 1'b0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mark_ff      <= mark_in;
         ready_ff     <= ready_in;
         total_ff     <= total_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The chain of cells: cell 0 takes the new sample, the last cell holds
   // the oldest one.
   for (genvar k = 0; k < mals_pkg::WINDOW_LENGTH; k++) begin : g_cell
      if (k == 0) begin : g_head
         mals_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .fill_sample (sample_u),
            .shift_in    (sample_u),
            .sample_out  (cell_sample[k])
         );
      end else begin : g_body
         mals_cell u_cell (
            .clock       (clock),
            .ctrl        (cell_ctrl),
            .fill_sample (sample_u),
            .shift_in    (cell_sample[k-1]),
            .sample_out  (cell_sample[k])
         );
      end
   end

   // ------------------------------------------------------------------
   // Division, rounding and clamp; output register
   // ------------------------------------------------------------------
   // While the middle stage holds a beat the total cannot move, because no
   // new beat is accepted until that beat has gone on, so the total register
   // doubles as the middle stage's payload.
   logic [mals_pkg::LEVEL_W-1:0] level_calc;
   logic [mals_pkg::LEVEL_W-1:0] rsp_level_ff, rsp_level_in;

   mals_round u_round (
      .total     (total_ff),
      .level_max (level_max_ff),
      .level     (level_calc)
   );

   assign rsp_level_in = (out_adv && s1_valid_ff) ? level_calc : rsp_level_ff;

   always_ff @(posedge clock) begin
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = rsp_level_ff;

`ifndef ASSERT_OFF
   // A beat in the middle stage behind a stalled result blocks the input.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while both pipeline stages are held");

   // A beat leaving the middle stage lands in the output register.
   a_middle_to_output: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_adv) |=> rsp_valid_ff)
      else $error("middle stage beat lost on its way to the output");

   // Any accepted beat leaves the window filled and ready.
   a_accept_makes_ready: assert property (@(posedge clock) disable iff (reset)
      accept |=> ready_ff)
      else $error("window not ready after an accepted beat");

   // A refill beat always enters the middle stage with a filled window total.
   a_refill_total: assert property (@(posedge clock) disable iff (reset)
      (accept && refill) |=> (s1_valid_ff && total_ff == $past(fill_total)))
      else $error("refill did not load the scaled sample into the total");
`endif

endmodule
`default_nettype wire

/* test/tb_moving_average_level_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average level smoother testbench
// Drives level beats with random timestamps and handshake gaps through several
// register settings; checks every level against a row's fixed level or an
// in-bench prediction of the windowed average, refill rule, rounding and clamp.
// ----------------------------------------------------------------------------
module tb_moving_average_level_smoother;

   // Slack after the last expected level has drained.
   localparam int DRAIN_CYCLES  = 8;
   localparam int PROBE_ROWS    = 19;
   localparam int PHASES        = 6;
   localparam int PHASE_BEATS   = 300;
   localparam int MAX_GAP       = 16;
   localparam int REPORT_LIMIT  = 10;
   // A row level of this value means the prediction supplies the expectation.
   localparam int LEVEL_PREDICTED = -1;
   localparam logic [mals_pkg::CSR_ADDR_W-1:0] ADDR_INTERVAL  =
      {mals_pkg::CSR_IDX_INTERVAL, 2'b00};
   localparam logic [mals_pkg::CSR_ADDR_W-1:0] ADDR_LEVEL_MAX =
      {mals_pkg::CSR_IDX_LEVEL_MAX, 2'b00};

   logic clock = 1'b0;
   logic reset;

   logic                                  req_valid;
   logic                                  req_ready;
   logic signed [mals_pkg::SAMPLE_W-1:0]  req_sample;
   logic        [mals_pkg::TIME_W-1:0]    req_now_ms;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic        [mals_pkg::LEVEL_W-1:0]   rsp_level;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic        [mals_pkg::CSR_ADDR_W-1:0] paddr;
   logic        [mals_pkg::CSR_DATA_W-1:0] pwdata;
   logic        [mals_pkg::CSR_DATA_W-1:0] prdata;
   logic                                  pready;

   moving_average_level_smoother u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_now_ms (req_now_ms),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_level  (rsp_level),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Prediction state. It mirrors the block: the window of samples, their
   // running sum, the slot that holds the oldest sample, whether the window
   // has been filled since the last refill, and the time of that refill.
   // ------------------------------------------------------------------------
   logic signed [mals_pkg::SAMPLE_W-1:0]   level_window [mals_pkg::WINDOW_LENGTH];
   logic signed [mals_pkg::TOTAL_W-1:0]    level_sum;
   int                                     next_slot;
   logic                                   window_primed;
   logic        [mals_pkg::TIME_W-1:0]     refill_mark;
   logic        [mals_pkg::INTERVAL_W-1:0] cfg_interval;
   logic        [mals_pkg::LEVEL_W-1:0]    cfg_level_max;

   logic [mals_pkg::LEVEL_W-1:0] pending_levels [$];
   int                           mismatches;
   int                           levels_seen;
   logic                         send_burst;
   logic                         take_burst;

   typedef struct packed {
      logic signed [mals_pkg::SAMPLE_W-1:0] sample;
      logic        [mals_pkg::TIME_W-1:0]   now_ms;
      logic signed [31:0]                   level;
   } probe_row_type;

   // Directed rows, run with the reset values of the registers (interval
   // 10000 ms, maximum level 5). Each comment gives the case the row covers.
   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{ 8'sd3,    32'd0,          32'sd3 },           // first beat fills
      '{ 8'sd127,  32'd5,          32'sd5 },           // large average clamps
      '{ -8'sd128, 32'd10000,      LEVEL_PREDICTED },  // gap equal to interval
      '{ -8'sd128, 32'd10001,      32'sd0 },           // gap beyond interval
      '{ -8'sd128, 32'd10002,      32'sd0 },           // most negative window
      '{ 8'sd0,    32'd20001,      LEVEL_PREDICTED },
      '{ 8'sd5,    32'd20002,      32'sd5 },           // refill again
      '{ 8'sd4,    32'd20003,      LEVEL_PREDICTED },
      '{ -8'sd1,   32'hFFFF_FFFF,  32'sd0 },           // refill at top of time
      '{ 8'sd4,    32'h0000_0005,  LEVEL_PREDICTED },  // time wraps, half below 0
      '{ 8'sd9,    32'd10000,      32'sd5 },           // refill after the wrap
      '{ 8'sd0,    32'd10001,      LEVEL_PREDICTED },
      '{ 8'sd3,    32'd20001,      32'sd3 },
      '{ 8'sd8,    32'd20002,      LEVEL_PREDICTED },  // sum 35 rounds up to 4
      '{ -8'sd128, 32'd20004,      LEVEL_PREDICTED },
      '{ 8'sd127,  32'd30002,      32'sd5 },
      '{ -8'sd128, 32'd30003,      LEVEL_PREDICTED },
      '{ 8'sd0,    32'h8000_0000,  32'sd0 },
      '{ 8'sd1,    32'h7FFF_FFFF,  32'sd1 }            // elapsed wraps to all ones
   };

   // Works out the level that one accepted beat produces and advances the
   // predicted window state.
   function automatic logic [mals_pkg::LEVEL_W-1:0] smoothed_level(
         input logic signed [mals_pkg::SAMPLE_W-1:0] sample,
         input logic [mals_pkg::TIME_W-1:0] now_ms);
      logic [mals_pkg::TIME_W-1:0] elapsed;
      int                          avg;
      int                          sum;
      elapsed = now_ms - refill_mark;
      if (elapsed > mals_pkg::TIME_W'(cfg_interval)) begin
         window_primed = 1'b0;
         refill_mark   = now_ms;
      end
      if (!window_primed) begin
         for (int k = 0; k < mals_pkg::WINDOW_LENGTH; k++) level_window[k] = sample;
         level_sum     = mals_pkg::TOTAL_W'(sample * mals_pkg::WINDOW_LENGTH);
         next_slot     = 0;
         window_primed = 1'b1;
         avg           = sample;
      end else begin
         sum = level_sum;
         sum = sum - level_window[next_slot] + sample;
         level_sum = mals_pkg::TOTAL_W'(sum);
         level_window[next_slot] = sample;
         next_slot = (next_slot == mals_pkg::WINDOW_LENGTH - 1) ? 0 : next_slot + 1;
         // Round half away from zero.
         if (sum >= 0) begin
            avg = (2 * sum + mals_pkg::WINDOW_LENGTH) / (2 * mals_pkg::WINDOW_LENGTH);
         end else begin
            avg = -((-2 * sum + mals_pkg::WINDOW_LENGTH) / (2 * mals_pkg::WINDOW_LENGTH));
         end
      end
      if (avg < 0) return '0;
      if (avg > int'(cfg_level_max)) return cfg_level_max;
      return mals_pkg::LEVEL_W'(avg);
   endfunction

   task automatic note_mismatch(input string what, input longint expv, input longint gotv);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%t: %s: expected %0d, got %0d", $realtime, what, expv, gotv);
      end
   endtask

   // Idle length for one beat; a burst stretch runs with no idling at all.
   function automatic int draw_gap(inout logic burst);
      if ($urandom_range(0, 31) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // APB write: a setup phase, then the access phase, during which the
   // register takes the value at the edge where pready is seen high. The bus
   // goes idle before the next transfer.
   task automatic csr_write(input logic [mals_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [mals_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_INTERVAL) cfg_interval = mals_pkg::INTERVAL_W'(data);
      else cfg_level_max = mals_pkg::LEVEL_W'(data);
      @(posedge clock);
   endtask

   // APB read, checked against the predicted register value.
   task automatic csr_check(input logic [mals_pkg::CSR_ADDR_W-1:0] addr);
      logic [mals_pkg::CSR_DATA_W-1:0] want;
      want = (addr == ADDR_INTERVAL) ? mals_pkg::CSR_DATA_W'(cfg_interval)
                                     : mals_pkg::CSR_DATA_W'(cfg_level_max);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) note_mismatch("register read-back", want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Offers one beat after a random gap and waits for it to be taken. The
   // valid stays high into the next beat when that beat draws no gap.
   task automatic send_beat(input logic signed [mals_pkg::SAMPLE_W-1:0] sample,
                            input logic [mals_pkg::TIME_W-1:0] now_ms,
                            input int fixed_level);
      int                           gap;
      logic [mals_pkg::LEVEL_W-1:0] predicted;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= sample;
      req_now_ms <= now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = smoothed_level(sample, now_ms);
      if (fixed_level == LEVEL_PREDICTED) pending_levels.push_back(predicted);
      else pending_levels.push_back(mals_pkg::LEVEL_W'(fixed_level));
   endtask

   task automatic wait_drained();
      while (pending_levels.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Result side: stalls at random, then checks each level beat against the
   // oldest expectation.
   // ------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap(take_burst);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         levels_seen++;
         if (pending_levels.size() == 0) begin
            note_mismatch("level beat with nothing pending", -1, rsp_level);
         end else if (rsp_level !== pending_levels[0]) begin
            note_mismatch($sformatf("level of beat %0d", levels_seen),
                          pending_levels[0], rsp_level);
            void'(pending_levels.pop_front());
         end else begin
            void'(pending_levels.pop_front());
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence: reset, directed rows under the reset register values,
   // then random phases, each under its own register setting.
   // ------------------------------------------------------------------------
   initial begin
      logic [mals_pkg::INTERVAL_W-1:0]      phase_interval [PHASES];
      logic [mals_pkg::LEVEL_W-1:0]         phase_level_max [PHASES];
      logic [mals_pkg::TIME_W-1:0]          clock_ms;
      logic [mals_pkg::TIME_W-1:0]          step_ms;
      logic signed [mals_pkg::SAMPLE_W-1:0] sample;
      int                                   pick;

      // Extremes first, then a small interval, then two random settings.
      phase_interval  = '{20'd0, 20'd1000000, 20'd1000000, 20'd37, 20'd0, 20'd0};
      phase_level_max = '{7'd127, 7'd127, 7'd0, 7'd64, 7'd0, 7'd0};
      for (int p = 4; p < PHASES; p++) begin
         phase_interval[p]  = mals_pkg::INTERVAL_W'($urandom_range(0, 1000000));
         phase_level_max[p] = mals_pkg::LEVEL_W'($urandom_range(0, 127));
      end

      req_valid  <= 1'b0;
      req_sample <= '0;
      req_now_ms <= '0;
      psel       <= 1'b0;
      penable    <= 1'b0;
      pwrite     <= 1'b0;
      paddr      <= '0;
      pwdata     <= '0;
      reset      <= 1'b1;
      mismatches  = 0;
      levels_seen = 0;
      send_burst  = 1'b0;
      take_burst  = 1'b0;

      // Predicted state after reset. The window contents are never read
      // before the first beat fills them.
      for (int k = 0; k < mals_pkg::WINDOW_LENGTH; k++) level_window[k] = '0;
      level_sum     = '0;
      next_slot     = 0;
      window_primed = 1'b0;
      refill_mark   = '0;
      cfg_interval  = mals_pkg::INTERVAL_RESET;
      cfg_level_max = mals_pkg::LEVEL_MAX_RESET;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(ADDR_INTERVAL);
      csr_check(ADDR_LEVEL_MAX);

      for (int r = 0; r < PROBE_ROWS; r++) begin
         send_beat(probe_rows[r].sample, probe_rows[r].now_ms, probe_rows[r].level);
      end
      clock_ms = probe_rows[PROBE_ROWS-1].now_ms;

      for (int p = 0; p < PHASES; p++) begin
         // Registers change only once the pipeline has emptied.
         req_valid <= 1'b0;
         wait_drained();
         csr_write(ADDR_INTERVAL, mals_pkg::CSR_DATA_W'(phase_interval[p]));
         csr_write(ADDR_LEVEL_MAX, mals_pkg::CSR_DATA_W'(phase_level_max[p]));
         csr_check(ADDR_INTERVAL);
         csr_check(ADDR_LEVEL_MAX);

         for (int n = 0; n < PHASE_BEATS; n++) begin
            // Mostly short steps, so the window runs through many slots
            // between refills; gaps exactly at and just past the interval
            // probe the refill boundary, and wild jumps wrap the time.
            pick = $urandom_range(0, 99);
            if (pick < 60) step_ms = $urandom_range(0, cfg_interval / 8 + 3);
            else if (pick < 70) step_ms = mals_pkg::TIME_W'(cfg_interval);
            else if (pick < 80) step_ms = mals_pkg::TIME_W'(cfg_interval) + 1;
            else if (pick < 85) step_ms = '0;
            else step_ms = $urandom;
            clock_ms = clock_ms + step_ms;

            pick = $urandom_range(0, 99);
            if (pick < 50) sample = mals_pkg::SAMPLE_W'($urandom);
            else if (pick < 80) sample = mals_pkg::SAMPLE_W'($urandom_range(0, 127));
            else sample = mals_pkg::SAMPLE_W'($urandom_range(0, 15));

            send_beat(sample, clock_ms, LEVEL_PREDICTED);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_levels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Well beyond the slowest correct run: about 1800 beats, each with a random
   // gap on both sides plus the time through the pipeline.
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
